[hdl/tic_pkg.sv]
package tic_pkg;

   // Fixed shape of the address unit.
   localparam int MAX_AXES   = 4;
   localparam int COORD_BITS = 12;
   localparam int FLAT_BITS  = 48;
   localparam int SIZE_BITS  = 13;
   localparam int ACC_BITS   = FLAT_BITS + 1;
   localparam int AXIS_BITS  = $clog2(MAX_AXES);
   localparam int COUNT_BITS = 3;
   localparam int REQ_BITS   = 2;

   // Offset-to-index division: quotient bits resolved per stage.
   localparam int DIV_CHUNK  = 8;
   localparam int DIV_STAGES = FLAT_BITS / DIV_CHUNK;
   localparam int DIV_STEPS  = MAX_AXES - 1;
   localparam int DIV_TOTAL  = DIV_STEPS * DIV_STAGES;

   // Port widths.
   localparam int REQ_FIELD_BITS = FLAT_BITS + MAX_AXES * COORD_BITS + AXIS_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = FLAT_BITS + MAX_AXES * COORD_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1 << COORD_BITS);

   // Request kinds.
   typedef enum logic [REQ_BITS-1:0] {
      REQ_TO_FLAT  = 2'd0,
      REQ_TO_COORD = 2'd1,
      REQ_STRIDE   = 2'd2
   } req_code_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_AXIS_COUNT = 3'd0,
      CSR_LAYOUT     = 3'd1,
      CSR_SIZE_0     = 3'd2,
      CSR_SIZE_1     = 3'd3,
      CSR_SIZE_2     = 3'd4,
      CSR_SIZE_3     = 3'd5
   } csr_index_type;

   typedef logic [MAX_AXES-1:0][COORD_BITS-1:0] coord_vec_type;

   // Configuration after clamping to legal ranges.
   typedef struct packed {
      logic [COUNT_BITS-1:0]               count;
      logic                                layout;
      logic [MAX_AXES-1:0][SIZE_BITS-1:0]  size;
   } tic_cfg_type;

   // Item state through the multiply-accumulate stages.
   typedef struct packed {
      logic [REQ_BITS-1:0]  req;
      logic [FLAT_BITS-1:0] flat_in;
      coord_vec_type        coords;
      logic [AXIS_BITS-1:0] axis_sel;
      logic [ACC_BITS-1:0]  acc;
      logic                 err;
   } tic_mac_item_type;

   // Item state through the division stages.
   typedef struct packed {
      logic [REQ_BITS-1:0]   req;
      logic                  err;
      logic [FLAT_BITS-1:0]  flat_out;
      logic [FLAT_BITS-1:0]  quo;
      logic [COORD_BITS-1:0] rem;
      coord_vec_type         coords;
   } tic_div_item_type;

   // Axis whose index falls out of division step k (fastest axis first).
   function automatic logic [AXIS_BITS-1:0] step_axis(input logic layout, input int k);
      return layout ? AXIS_BITS'(k) : AXIS_BITS'(MAX_AXES - 1 - k);
   endfunction

   // Divisor of step k; a step that has no axis of its own divides by one.
   function automatic logic [SIZE_BITS-1:0] step_divisor(input tic_cfg_type cfg, input int k);
      logic [AXIS_BITS-1:0] ax;
      logic                 is_split;
      ax = step_axis(cfg.layout, k);
      if (cfg.layout) begin
         is_split = (COUNT_BITS'(ax) + COUNT_BITS'(1)) < cfg.count;
      end else begin
         is_split = COUNT_BITS'(ax) < cfg.count;
      end
      return is_split ? cfg.size[ax] : SIZE_BITS'(1);
   endfunction

endpackage

[hdl/tic_mac_step.sv]
module tic_mac_step #(
   parameter int POS = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  tic_pkg::tic_cfg_type      cfg,
   input  logic                      in_valid,
   input  tic_pkg::tic_mac_item_type in_item,
   output logic                      out_valid,
   output tic_pkg::tic_mac_item_type out_item
);
   import tic_pkg::*;

   localparam int PROD_BITS = ACC_BITS + SIZE_BITS;
   localparam logic [AXIS_BITS-1:0] ROW_AXIS = AXIS_BITS'(POS);
   localparam logic [AXIS_BITS-1:0] COL_AXIS = AXIS_BITS'(MAX_AXES - 1 - POS);

   logic [AXIS_BITS-1:0]  axis;
   logic                  used;
   logic                  faster;
   logic [COUNT_BITS-1:0] sel_clamp;
   logic [SIZE_BITS-1:0]  ax_size;
   logic [SIZE_BITS-1:0]  mult;
   logic [COORD_BITS-1:0] coord;
   logic [COORD_BITS-1:0] addend;
   logic [PROD_BITS-1:0]  prod;
   logic                  range_hit;
   tic_mac_item_type      out_item_in;
   logic                  out_valid_ff;
   tic_mac_item_type      out_item_ff;

   // Positions run from the slowest axis to the fastest one.
   always_comb begin
      axis      = cfg.layout ? COL_AXIS : ROW_AXIS;
      used      = COUNT_BITS'(axis) < cfg.count;
      sel_clamp = (COUNT_BITS'(in_item.axis_sel) > cfg.count) ?
                  cfg.count : COUNT_BITS'(in_item.axis_sel);
      faster    = cfg.layout ? (COUNT_BITS'(axis) < sel_clamp) :
                               (COUNT_BITS'(axis) > sel_clamp);
      ax_size   = cfg.size[axis];
      coord     = in_item.coords[axis];
      range_hit = 1'b0;
      mult      = SIZE_BITS'(1);
      addend    = '0;
      case (in_item.req)
         REQ_TO_FLAT: begin
            if (used) begin
               mult      = ax_size;
               addend    = coord;
               range_hit = SIZE_BITS'(coord) >= ax_size;
            end
         end
         REQ_TO_COORD: begin
            // Builds the element count for the range check.
            if (used) begin
               mult = ax_size;
            end
         end
         REQ_STRIDE: begin
            if (used && faster) begin
               mult = ax_size;
            end
         end
         default: begin
            mult = SIZE_BITS'(1);
         end
      endcase
   end

   // One Horner step: acc * extent + index.
   always_comb begin
      prod            = in_item.acc * mult;
      out_item_in     = in_item;
      out_item_in.acc = prod[ACC_BITS-1:0] + ACC_BITS'(addend);
      out_item_in.err = in_item.err | range_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

[hdl/tic_div_step.sv]
module tic_div_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [tic_pkg::SIZE_BITS-1:0] divisor,
   input  logic                          in_valid,
   input  tic_pkg::tic_div_item_type     in_item,
   output logic                          out_valid,
   output tic_pkg::tic_div_item_type     out_item
);
   import tic_pkg::*;

   logic [SIZE_BITS-1:0] part;
   logic                 take;
   tic_div_item_type     out_item_in;
   logic                 out_valid_ff;
   tic_div_item_type     out_item_ff;

   // Restoring division: dividend bits leave the top of quo while quotient
   // bits enter at the bottom. The remainder stays below the divisor.
   always_comb begin
      out_item_in = in_item;
      part        = '0;
      take        = 1'b0;
      for (int i = 0; i < DIV_CHUNK; i++) begin
         part = {out_item_in.rem, out_item_in.quo[FLAT_BITS-1]};
         take = part >= divisor;
         out_item_in.quo = {out_item_in.quo[FLAT_BITS-2:0], take};
         if (take) begin
            part = part - divisor;
         end
         out_item_in.rem = part[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_item_ff <= out_item_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

[hdl/tensor_index_converter.sv]
// Throughput: one request per cycle unless rsp_tready holds the output back; the
// whole pipeline advances together. The pipeline is one capture stage, four
// multiply-accumulate stages, eighteen division stages (three divisions of six
// stages, eight quotient bits per stage) and an output stage. Synchronous reset
// empties the pipeline and restores the configuration defaults.
module tensor_index_converter (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: flat_in, coord_0, coord_1, coord_2, coord_3, axis_sel, zero fill
   input  logic [tic_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: req_type
   input  logic [tic_pkg::REQ_BITS-1:0]       req_tuser,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: flat_out, coord_out_0, coord_out_1, coord_out_2, coord_out_3
   output logic [tic_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // tuser: range_error
   output logic                               rsp_tuser,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [tic_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tic_pkg::SIZE_BITS-1:0]      csr_wdata
);
   import tic_pkg::*;

   logic [COUNT_BITS-1:0]              axis_count_ff;
   logic                               layout_ff;
   logic [MAX_AXES-1:0][SIZE_BITS-1:0] size_ff;
   tic_cfg_type                        cfg;

   logic             adv;
   tic_mac_item_type req_item;
   logic             skid_valid_ff;
   tic_mac_item_type skid_item_ff;
   logic             feed_valid;
   tic_mac_item_type feed_item;
   logic             cap_valid_ff;
   tic_mac_item_type cap_item_ff;

   logic             mac_valid [MAX_AXES+1];
   tic_mac_item_type mac_item  [MAX_AXES+1];
   logic             div_valid [DIV_TOTAL+1];
   tic_div_item_type div_item  [DIV_TOTAL+1];
   tic_div_item_type div_load_item;

   tic_div_item_type      fin_item;
   logic [AXIS_BITS-1:0]  slowest;
   logic                  rsp_valid_ff;
   logic [FLAT_BITS-1:0]  rsp_flat_ff;
   logic [FLAT_BITS-1:0]  rsp_flat_in;
   coord_vec_type         rsp_coords_ff;
   coord_vec_type         rsp_coords_in;
   logic                  rsp_err_ff;
   logic                  rsp_err_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff <= COUNT_BITS'(1);
         layout_ff     <= 1'b0;
         for (int a = 0; a < MAX_AXES; a++) begin
            size_ff[a] <= SIZE_BITS'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_AXIS_COUNT: axis_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_LAYOUT:     layout_ff     <= csr_wdata[0];
            CSR_SIZE_0:     size_ff[0]    <= csr_wdata;
            CSR_SIZE_1:     size_ff[1]    <= csr_wdata;
            CSR_SIZE_2:     size_ff[2]    <= csr_wdata;
            CSR_SIZE_3:     size_ff[3]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp the axis count and the extents into their legal ranges.
   always_comb begin
      cfg.layout = layout_ff;
      if (axis_count_ff == '0) begin
         cfg.count = COUNT_BITS'(1);
      end else if (axis_count_ff > COUNT_BITS'(MAX_AXES)) begin
         cfg.count = COUNT_BITS'(MAX_AXES);
      end else begin
         cfg.count = axis_count_ff;
      end
      for (int a = 0; a < MAX_AXES; a++) begin
         if (size_ff[a] == '0) begin
            cfg.size[a] = SIZE_BITS'(1);
         end else if (size_ff[a] > SIZE_CAP) begin
            cfg.size[a] = SIZE_CAP;
         end else begin
            cfg.size[a] = size_ff[a];
         end
      end
   end

   // The whole pipeline moves unless the output register is full and stalled.
   assign adv = !rsp_valid_ff || rsp_tready;

   // Unpack a request; index-to-offset starts its sum at zero, the others
   // start a product at one.
   always_comb begin
      req_item.req      = req_tuser;
      req_item.flat_in  = req_tdata[FLAT_BITS-1:0];
      req_item.coords   = req_tdata[FLAT_BITS +: MAX_AXES*COORD_BITS];
      req_item.axis_sel = req_tdata[FLAT_BITS + MAX_AXES*COORD_BITS +: AXIS_BITS];
      req_item.acc      = (req_tuser == REQ_TO_FLAT) ? '0 : ACC_BITS'(1);
      req_item.err      = 1'b0;
   end

   // Skid register keeps req_tready independent of rsp_tready.
   assign req_tready = !skid_valid_ff;
   assign feed_valid = skid_valid_ff || req_tvalid;
   assign feed_item  = skid_valid_ff ? skid_item_ff : req_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         cap_valid_ff  <= 1'b0;
      end else if (adv) begin
         skid_valid_ff <= 1'b0;
         cap_valid_ff  <= feed_valid;
      end else if (req_tvalid && req_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cap_item_ff <= feed_item;
      end else if (req_tvalid && req_tready) begin
         skid_item_ff <= req_item;
      end
   end

   // Multiply-accumulate stages, slowest axis first.
   assign mac_valid[0] = cap_valid_ff;
   assign mac_item[0]  = cap_item_ff;

   for (genvar p = 0; p < MAX_AXES; p++) begin : g_mac
      tic_mac_step #(
         .POS (p)
      ) u_mac (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .cfg       (cfg),
         .in_valid  (mac_valid[p]),
         .in_item   (mac_item[p]),
         .out_valid (mac_valid[p+1]),
         .out_item  (mac_item[p+1])
      );
   end

   // Settle the flat result and the error flag, then load the divider.
   always_comb begin
      div_load_item.req      = mac_item[MAX_AXES].req;
      div_load_item.quo      = mac_item[MAX_AXES].flat_in;
      div_load_item.rem      = '0;
      div_load_item.coords   = '0;
      div_load_item.flat_out = '0;
      div_load_item.err      = mac_item[MAX_AXES].err;
      case (mac_item[MAX_AXES].req)
         REQ_TO_FLAT, REQ_STRIDE: begin
            div_load_item.flat_out = mac_item[MAX_AXES].acc[FLAT_BITS-1:0];
         end
         REQ_TO_COORD: begin
            if (ACC_BITS'(mac_item[MAX_AXES].flat_in) >= mac_item[MAX_AXES].acc) begin
               div_load_item.err = 1'b1;
            end
         end
         default: begin
            div_load_item.err = 1'b1;
         end
      endcase
   end

   assign div_valid[0] = mac_valid[MAX_AXES];
   assign div_item[0]  = div_load_item;

   // Division stages; each division peels the fastest remaining axis.
   for (genvar s = 0; s < DIV_TOTAL; s++) begin : g_div
      localparam int K = s / DIV_STAGES;
      localparam int J = s % DIV_STAGES;

      tic_div_item_type div_feed;

      // At the start of a new division, the last remainder becomes an index.
      always_comb begin
         div_feed = div_item[s];
         if (J == 0 && K > 0) begin
            div_feed.coords[step_axis(cfg.layout, K - 1)] = div_item[s].rem;
            div_feed.rem = '0;
         end
      end

      tic_div_step u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .divisor   (step_divisor(cfg, K)),
         .in_valid  (div_valid[s]),
         .in_item   (div_feed),
         .out_valid (div_valid[s+1]),
         .out_item  (div_item[s+1])
      );
   end

   // Final indices: last remainder, then the slowest axis takes the quotient.
   always_comb begin
      fin_item = div_item[DIV_TOTAL];
      slowest  = cfg.layout ? AXIS_BITS'(cfg.count - COUNT_BITS'(1)) : '0;
      fin_item.coords[step_axis(cfg.layout, DIV_STEPS - 1)] = fin_item.rem;
      fin_item.coords[slowest] = fin_item.quo[COORD_BITS-1:0];
      rsp_flat_in = fin_item.flat_out;
      rsp_err_in  = fin_item.err;
      if (fin_item.req == REQ_TO_COORD) begin
         rsp_coords_in = fin_item.coords;
      end else begin
         rsp_coords_in = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid[DIV_TOTAL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_flat_ff   <= rsp_flat_in;
         rsp_coords_ff <= rsp_coords_in;
         rsp_err_ff    <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_coords_ff, rsp_flat_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule
